// ----- src/ddn_pkg.sv -----
// ----------------------------------------------------------------------------
// ddn_pkg
// Types, constants, microcode and calendar helpers for the date / day number
// converter.
// ----------------------------------------------------------------------------
package ddn_pkg;

  localparam int unsigned OpW    = 1;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 17;
  localparam int unsigned WkW    = 3;
  localparam int unsigned LenW   = 9;

  localparam logic [CountW-1:0] CountMax  = '1;
  localparam logic [MonthW-1:0] LastMonth = MonthW'(12);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_CHK,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_RANGE,
    S_OUT0,
    S_IYEAR,
    S_IMONTH,
    S_IDAY,
    S_OUT1,
    S_BAD
  } step_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_NO_IN,
    C_OP1,
    C_BAD_DATE,
    C_YEAR_EQ,
    C_MONTH_EQ,
    C_WIDE,
    C_OUT_BUSY,
    C_FITS_YEAR,
    C_FITS_MONTH
  } cond_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_ADD_YLEN,
    ACT_ADD_MLEN,
    ACT_ADD_DAY,
    ACT_SUB_YLEN,
    ACT_SUB_MLEN,
    ACT_ADD_REM,
    ACT_WR_OK0,
    ACT_WR_OK1,
    ACT_WR_BAD
  } act_e;

  // cond true: jump to target; otherwise run act and go to next.
  // trap_end overrides both when the year counter sits past the span.
  typedef struct packed {
    cond_e cond;
    step_e target;
    act_e  act;
    step_e next;
    logic  trap_end;
  } uword_t;

  typedef struct packed {
    logic op;
    logic bad_date;
    logic year_eq;
    logic month_eq;
    logic wide;
    logic fits_year;
    logic fits_month;
    logic at_end;
  } dp_stat_t;

  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '{C_NEVER, S_IDLE, ACT_NONE, S_IDLE, 1'b0};
    case (s)
      S_IDLE:   w = '{C_NO_IN,      S_IDLE,   ACT_LOAD,     S_DISP,   1'b0};
      S_DISP:   w = '{C_OP1,        S_IYEAR,  ACT_NONE,     S_CHK,    1'b0};
      S_CHK:    w = '{C_BAD_DATE,   S_BAD,    ACT_NONE,     S_YEAR,   1'b0};
      S_YEAR:   w = '{C_YEAR_EQ,    S_MONTH,  ACT_ADD_YLEN, S_YEAR,   1'b0};
      S_MONTH:  w = '{C_MONTH_EQ,   S_DAY,    ACT_ADD_MLEN, S_MONTH,  1'b0};
      S_DAY:    w = '{C_NEVER,      S_IDLE,   ACT_ADD_DAY,  S_RANGE,  1'b0};
      S_RANGE:  w = '{C_WIDE,       S_BAD,    ACT_NONE,     S_OUT0,   1'b0};
      S_OUT0:   w = '{C_OUT_BUSY,   S_OUT0,   ACT_WR_OK0,   S_IDLE,   1'b0};
      S_IYEAR:  w = '{C_FITS_YEAR,  S_IMONTH, ACT_SUB_YLEN, S_IYEAR,  1'b1};
      S_IMONTH: w = '{C_FITS_MONTH, S_IDAY,   ACT_SUB_MLEN, S_IMONTH, 1'b0};
      S_IDAY:   w = '{C_NEVER,      S_IDLE,   ACT_ADD_REM,  S_OUT1,   1'b0};
      S_OUT1:   w = '{C_OUT_BUSY,   S_OUT1,   ACT_WR_OK1,   S_IDLE,   1'b0};
      S_BAD:    w = '{C_OUT_BUSY,   S_BAD,    ACT_WR_BAD,   S_IDLE,   1'b0};
      default:  w = '{C_NEVER,      S_IDLE,   ACT_NONE,     S_IDLE,   1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [DayW-1:0] month_days(logic [MonthW-1:0] m, logic leap);
    logic [DayW-1:0] d;
    d = DayW'(31);
    case (m)
      MonthW'(2):  d = leap ? DayW'(29) : DayW'(28);
      MonthW'(4),
      MonthW'(6),
      MonthW'(9),
      MonthW'(11): d = DayW'(30);
      default:     d = DayW'(31);
    endcase
    return d;
  endfunction

  function automatic logic [WkW-1:0] mod7(logic [DayW-1:0] v);
    logic [DayW-1:0] r;
    r = v;
    if (r >= DayW'(28)) r = r - DayW'(28);
    if (r >= DayW'(14)) r = r - DayW'(14);
    if (r >= DayW'(7))  r = r - DayW'(7);
    return r[WkW-1:0];
  endfunction

  function automatic logic [WkW-1:0] wk_add(logic [WkW-1:0] a, logic [WkW-1:0] b);
    logic [WkW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (WkW+1)'(7)) s = s - (WkW+1)'(7);
    return s[WkW-1:0];
  endfunction

endpackage

// ----- src/ddn_if.sv -----
// ----------------------------------------------------------------------------
// ddn_if
// Valid/ready channels of the converter: request and result transactions.
// ----------------------------------------------------------------------------
interface ddn_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddn_pkg::OpW-1:0]      op;
  logic [ddn_pkg::YearW-1:0]    year;
  logic [ddn_pkg::MonthW-1:0]   month;
  logic [ddn_pkg::DayW-1:0]     day;
  logic [ddn_pkg::CountW-1:0]   day_count;

  modport source (output valid, op, year, month, day, day_count, input ready);
  modport sink   (input valid, op, year, month, day, day_count, output ready);
endinterface

interface ddn_out_if;
  logic                         valid;
  logic                         ready;
  logic [ddn_pkg::CountW-1:0]   count_out;
  logic [ddn_pkg::YearW-1:0]    year_out;
  logic [ddn_pkg::MonthW-1:0]   month_out;
  logic [ddn_pkg::DayW-1:0]     day_out;
  logic [ddn_pkg::WkW-1:0]      weekday;
  logic                         valid_res;

  modport source (output valid, count_out, year_out, month_out, day_out, weekday, valid_res,
                  input ready);
  modport sink   (input valid, count_out, year_out, month_out, day_out, weekday, valid_res,
                  output ready);
endinterface

// ----- src/ddn_datapath.sv -----
// ----------------------------------------------------------------------------
// ddn_datapath
// Accumulator, year/month counters, leap tracking and weekday residue, driven
// one action per step by the microcode sequencer.
// ----------------------------------------------------------------------------
module ddn_datapath #(
  parameter int unsigned YEAR_SPAN = 256,
  parameter int unsigned BASE_YEAR = 1900,
  parameter int unsigned AccW      = 19
) (
  input  logic                        clk_i,
  input  ddn_pkg::act_e               act_i,
  input  logic [ddn_pkg::OpW-1:0]     op_i,
  input  logic [ddn_pkg::YearW-1:0]   year_i,
  input  logic [ddn_pkg::MonthW-1:0]  month_i,
  input  logic [ddn_pkg::DayW-1:0]    day_i,
  input  logic [ddn_pkg::CountW-1:0]  day_count_i,
  output ddn_pkg::dp_stat_t           stat_o,
  output logic [AccW-1:0]             acc_o,
  output logic [ddn_pkg::YearW-1:0]   year_o,
  output logic [ddn_pkg::MonthW-1:0]  month_o,
  output logic [ddn_pkg::WkW-1:0]     wk_o
);

  localparam int unsigned EndYear = BASE_YEAR + YEAR_SPAN;
  localparam int unsigned BaseP   = BASE_YEAR - 1;
  localparam int unsigned BaseWk  = (BaseP * 365 + BaseP / 4 - BaseP / 100 + BaseP / 400) % 7;
  localparam int unsigned Mod100  = BASE_YEAR % 100;
  localparam int unsigned Mod400  = BASE_YEAR % 400;

  localparam logic [ddn_pkg::YearW-1:0] BaseYearV = ddn_pkg::YearW'(BASE_YEAR);
  localparam logic [ddn_pkg::YearW-1:0] EndYearV  = ddn_pkg::YearW'(EndYear);

  logic [ddn_pkg::OpW-1:0]    op_q;
  logic [ddn_pkg::YearW-1:0]  year_q;
  logic [ddn_pkg::MonthW-1:0] month_q;
  logic [ddn_pkg::DayW-1:0]   day_q;

  logic [AccW-1:0]            acc_q;
  logic [ddn_pkg::YearW-1:0]  y_q;
  logic [6:0]                 y100_q;
  logic [8:0]                 y400_q;
  logic [ddn_pkg::MonthW-1:0] m_q;
  logic [ddn_pkg::WkW-1:0]    wk_q;

  logic                       leap;
  logic [ddn_pkg::LenW-1:0]   ylen;
  logic [ddn_pkg::DayW-1:0]   mlen;
  logic [ddn_pkg::WkW-1:0]    ywk;
  logic [ddn_pkg::DayW-1:0]   day_m1;

  assign leap   = (y400_q == '0) || ((y_q[1:0] == 2'd0) && (y100_q != '0));
  assign ylen   = leap ? ddn_pkg::LenW'(366) : ddn_pkg::LenW'(365);
  assign ywk    = leap ? ddn_pkg::WkW'(2) : ddn_pkg::WkW'(1);
  assign mlen   = ddn_pkg::month_days(m_q, leap);
  assign day_m1 = day_q - ddn_pkg::DayW'(1);

  always_ff @(posedge clk_i) begin
    case (act_i)
      ddn_pkg::ACT_LOAD: begin
        op_q    <= op_i;
        year_q  <= year_i;
        month_q <= month_i;
        day_q   <= day_i;
        acc_q   <= op_i[0] ? AccW'(day_count_i) : '0;
        y_q     <= BaseYearV;
        y100_q  <= 7'(Mod100);
        y400_q  <= 9'(Mod400);
        m_q     <= ddn_pkg::MonthW'(1);
        wk_q    <= ddn_pkg::WkW'(BaseWk);
      end
      ddn_pkg::ACT_ADD_YLEN,
      ddn_pkg::ACT_SUB_YLEN: begin
        acc_q  <= (act_i == ddn_pkg::ACT_ADD_YLEN) ? acc_q + AccW'(ylen) : acc_q - AccW'(ylen);
        wk_q   <= ddn_pkg::wk_add(wk_q, ywk);
        y_q    <= y_q + ddn_pkg::YearW'(1);
        y100_q <= (y100_q == 7'd99) ? '0 : y100_q + 7'd1;
        y400_q <= (y400_q == 9'd399) ? '0 : y400_q + 9'd1;
      end
      ddn_pkg::ACT_ADD_MLEN,
      ddn_pkg::ACT_SUB_MLEN: begin
        acc_q <= (act_i == ddn_pkg::ACT_ADD_MLEN) ? acc_q + AccW'(mlen) : acc_q - AccW'(mlen);
        wk_q  <= ddn_pkg::wk_add(wk_q, ddn_pkg::mod7(mlen));
        m_q   <= m_q + ddn_pkg::MonthW'(1);
      end
      ddn_pkg::ACT_ADD_DAY: begin
        acc_q <= acc_q + AccW'(day_m1);
        wk_q  <= ddn_pkg::wk_add(wk_q, ddn_pkg::mod7(day_m1));
      end
      ddn_pkg::ACT_ADD_REM: begin
        wk_q <= ddn_pkg::wk_add(wk_q, ddn_pkg::mod7(acc_q[ddn_pkg::DayW-1:0]));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.op         = op_q[0];
    stat_o.bad_date   = (month_q == '0) || (month_q > ddn_pkg::LastMonth) || (day_q == '0) ||
                        (year_q < BaseYearV) || (year_q >= EndYearV);
    stat_o.year_eq    = (y_q == year_q);
    stat_o.month_eq   = (m_q == month_q);
    stat_o.wide       = (acc_q > AccW'(ddn_pkg::CountMax));
    stat_o.fits_year  = (acc_q < AccW'(ylen));
    stat_o.fits_month = (m_q == ddn_pkg::LastMonth) || (acc_q < AccW'(mlen));
    stat_o.at_end     = (y_q == EndYearV);
  end

  assign acc_o   = acc_q;
  assign year_o  = y_q;
  assign month_o = m_q;
  assign wk_o    = wk_q;

endmodule

// ----- src/date_day_number_converter.sv -----
// ----------------------------------------------------------------------------
// date_day_number_converter
// Gregorian date <-> day number since January 1 of BASE_YEAR, with weekday.
// Throughput: one transaction at a time, one year or month step per cycle.
// Reset: sequencer returns to idle and the result register empties.
// ----------------------------------------------------------------------------
module date_day_number_converter #(
  parameter int unsigned YEAR_SPAN = 256,
  parameter int unsigned BASE_YEAR = 1900
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ddn_in_if.sink           in_i,
  ddn_out_if.source        out_o
);

  localparam int unsigned MaxDays = (YEAR_SPAN + 1) * 366;
  localparam int unsigned SpanW   = $clog2(MaxDays + 1);
  localparam int unsigned AccW    = (SpanW > ddn_pkg::CountW) ? SpanW : ddn_pkg::CountW;

  ddn_pkg::step_e             pc_q, pc_d;
  ddn_pkg::uword_t            uw;
  ddn_pkg::act_e              act;
  ddn_pkg::dp_stat_t          stat;
  logic                       cond;
  logic                       out_busy;

  logic [AccW-1:0]            acc;
  logic [ddn_pkg::YearW-1:0]  y;
  logic [ddn_pkg::MonthW-1:0] m;
  logic [ddn_pkg::WkW-1:0]    wk;

  logic                        out_valid_q;
  logic [ddn_pkg::CountW-1:0]  count_q;
  logic [ddn_pkg::YearW-1:0]   year_q;
  logic [ddn_pkg::MonthW-1:0]  month_q;
  logic [ddn_pkg::DayW-1:0]    day_q;
  logic [ddn_pkg::WkW-1:0]     wk_q;
  logic                        res_q;

  assign uw       = ddn_pkg::ucode(pc_q);
  assign out_busy = out_valid_q && !out_o.ready;

  always_comb begin
    case (uw.cond)
      ddn_pkg::C_NEVER:      cond = 1'b0;
      ddn_pkg::C_NO_IN:      cond = !in_i.valid;
      ddn_pkg::C_OP1:        cond = stat.op;
      ddn_pkg::C_BAD_DATE:   cond = stat.bad_date;
      ddn_pkg::C_YEAR_EQ:    cond = stat.year_eq;
      ddn_pkg::C_MONTH_EQ:   cond = stat.month_eq;
      ddn_pkg::C_WIDE:       cond = stat.wide;
      ddn_pkg::C_OUT_BUSY:   cond = out_busy;
      ddn_pkg::C_FITS_YEAR:  cond = stat.fits_year;
      ddn_pkg::C_FITS_MONTH: cond = stat.fits_month;
      default:               cond = 1'b0;
    endcase

    if (uw.trap_end && stat.at_end) begin
      pc_d = ddn_pkg::S_BAD;
      act  = ddn_pkg::ACT_NONE;
    end else if (cond) begin
      pc_d = uw.target;
      act  = ddn_pkg::ACT_NONE;
    end else begin
      pc_d = uw.next;
      act  = uw.act;
    end
  end

  assign in_i.ready = (pc_q == ddn_pkg::S_IDLE);

  ddn_datapath #(
    .YEAR_SPAN (YEAR_SPAN),
    .BASE_YEAR (BASE_YEAR),
    .AccW      (AccW)
  ) u_dp (
    .clk_i       (clk_i),
    .act_i       (act),
    .op_i        (in_i.op),
    .year_i      (in_i.year),
    .month_i     (in_i.month),
    .day_i       (in_i.day),
    .day_count_i (in_i.day_count),
    .stat_o      (stat),
    .acc_o       (acc),
    .year_o      (y),
    .month_o     (m),
    .wk_o        (wk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ddn_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (act == ddn_pkg::ACT_WR_OK0 || act == ddn_pkg::ACT_WR_OK1 ||
          act == ddn_pkg::ACT_WR_BAD) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (act)
      ddn_pkg::ACT_WR_OK0: begin
        count_q <= acc[ddn_pkg::CountW-1:0];
        year_q  <= '0;
        month_q <= '0;
        day_q   <= '0;
        wk_q    <= wk;
        res_q   <= 1'b1;
      end
      ddn_pkg::ACT_WR_OK1: begin
        count_q <= '0;
        year_q  <= y;
        month_q <= m;
        day_q   <= acc[ddn_pkg::DayW-1:0] + ddn_pkg::DayW'(1);
        wk_q    <= wk;
        res_q   <= 1'b1;
      end
      ddn_pkg::ACT_WR_BAD: begin
        count_q <= '0;
        year_q  <= '0;
        month_q <= '0;
        day_q   <= '0;
        wk_q    <= '0;
        res_q   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.count_out = count_q;
  assign out_o.year_out  = year_q;
  assign out_o.month_out = month_q;
  assign out_o.day_out   = day_q;
  assign out_o.weekday   = wk_q;
  assign out_o.valid_res = res_q;

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> pc_q == ddn_pkg::S_DISP)
    else $error("accepted transaction did not reach dispatch step");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q |-> count_q == '0 && year_q == '0 && month_q == '0 &&
                              day_q == '0 && wk_q == '0)
    else $error("rejected result carries nonzero fields");

  a_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == ddn_pkg::S_IMONTH |-> m <= ddn_pkg::LastMonth && m != '0)
    else $error("month counter left 1 to 12");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> wk_q < ddn_pkg::WkW'(7))
    else $error("weekday residue out of range");

endmodule

// ----- dv/tb_date_day_number_converter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_day_number_converter
// Drives date and day-count requests into the converter, including malformed
// months, day zero, years outside the span and counts past the span. Every
// result is compared field by field against an in-bench calendar predictor.
// Sender and receiver idle at random in two phases and never in a third, and
// one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_date_day_number_converter;

  localparam int unsigned SPAN        = 256;
  localparam int unsigned FIRST_YEAR  = 1900;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = SPAN + 20;

  typedef enum logic {
    OP_DATE_TO_COUNT = 1'b0,
    OP_COUNT_TO_DATE = 1'b1
  } conv_op_e;

  typedef struct packed {
    conv_op_e                     op;
    logic [ddn_pkg::YearW-1:0]    year;
    logic [ddn_pkg::MonthW-1:0]   month;
    logic [ddn_pkg::DayW-1:0]     day;
    logic [ddn_pkg::CountW-1:0]   day_count;
  } cal_req_t;

  typedef struct packed {
    logic [ddn_pkg::CountW-1:0]   count_out;
    logic [ddn_pkg::YearW-1:0]    year_out;
    logic [ddn_pkg::MonthW-1:0]   month_out;
    logic [ddn_pkg::DayW-1:0]     day_out;
    logic [ddn_pkg::WkW-1:0]      weekday;
    logic                         valid_res;
  } cal_res_t;

  logic clk;
  logic rst_n;

  ddn_in_if  in_if ();
  ddn_out_if out_if ();

  date_day_number_converter #(
    .YEAR_SPAN(SPAN),
    .BASE_YEAR(FIRST_YEAR)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  cal_res_t    expected_cal_q[$];
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_go;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned n_date_req;
  int unsigned n_count_req;
  int unsigned n_flagged;
  int unsigned n_results;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2:              len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:    len = 30;
      default:        len = 31;
    endcase
    return len;
  endfunction

  // Monday is 0; day 1 of year 1 was a Monday.
  function automatic int unsigned first_weekday();
    int unsigned p;
    p = FIRST_YEAR - 1;
    return (p * 365 + p / 4 - p / 100 + p / 400) % 7;
  endfunction

  function automatic int unsigned span_days();
    int unsigned total;
    total = 0;
    for (int unsigned y = FIRST_YEAR; y < FIRST_YEAR + SPAN; y++) total += days_in_year(y);
    return total;
  endfunction

  function automatic cal_res_t predict_conversion(cal_req_t rq);
    cal_res_t    res;
    int unsigned y;
    int unsigned m;
    int unsigned days;
    res  = '0;
    days = 0;
    if (rq.op == OP_DATE_TO_COUNT) begin
      if (rq.month < 1 || rq.month > 12 || rq.day == 0) return res;
      if (rq.year < FIRST_YEAR || rq.year >= FIRST_YEAR + SPAN) return res;
      for (y = FIRST_YEAR; y < rq.year; y++) days += days_in_year(y);
      for (m = 1; m < rq.month; m++) days += days_in_month(rq.year, m);
      days += rq.day - 1;
      if (days > ddn_pkg::CountMax) return res;
      res.count_out = ddn_pkg::CountW'(days);
      res.weekday   = ddn_pkg::WkW'((first_weekday() + days) % 7);
      res.valid_res = 1'b1;
      return res;
    end
    days = rq.day_count;
    y    = FIRST_YEAR;
    while (days >= days_in_year(y)) begin
      days -= days_in_year(y);
      y++;
      if (y >= FIRST_YEAR + SPAN) return res;
    end
    m = 1;
    while (m < 12 && days >= days_in_month(y, m)) begin
      days -= days_in_month(y, m);
      m++;
    end
    res.year_out  = ddn_pkg::YearW'(y);
    res.month_out = ddn_pkg::MonthW'(m);
    res.day_out   = ddn_pkg::DayW'(days + 1);
    res.weekday   = ddn_pkg::WkW'((first_weekday() + rq.day_count) % 7);
    res.valid_res = 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random ready, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker, expectation capture and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cal_res_t got;
    cal_res_t exp;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        n_results++;
        got = '{out_if.count_out, out_if.year_out, out_if.month_out, out_if.day_out,
                out_if.weekday, out_if.valid_res};
        if (!got.valid_res) n_flagged++;
        if (expected_cal_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("[%0t] unexpected result transaction", $realtime);
        end else begin
          exp = expected_cal_q.pop_front();
          if (got.count_out !== exp.count_out || got.year_out !== exp.year_out ||
              got.month_out !== exp.month_out || got.day_out !== exp.day_out ||
              got.weekday !== exp.weekday || got.valid_res !== exp.valid_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: exp cnt=%0d y=%0d m=%0d d=%0d wd=%0d ok=%0b",
                       $realtime, exp.count_out, exp.year_out, exp.month_out,
                       exp.day_out, exp.weekday, exp.valid_res);
              $display("               got cnt=%0d y=%0d m=%0d d=%0d wd=%0d ok=%0b",
                       got.count_out, got.year_out, got.month_out, got.day_out,
                       got.weekday, got.valid_res);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        expected_cal_q.push_back(predict_conversion('{conv_op_e'(in_if.op), in_if.year,
                                                       in_if.month, in_if.day,
                                                       in_if.day_count}));
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_request(cal_req_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= rq.op;
    in_if.year      <= rq.year;
    in_if.month     <= rq.month;
    in_if.day       <= rq.day;
    in_if.day_count <= rq.day_count;
    do @(posedge clk); while (!in_if.ready);
    if (rq.op == OP_DATE_TO_COUNT) n_date_req++;
    else n_count_req++;
  endtask

  task automatic send_date(int unsigned y, int unsigned m, int unsigned d);
    cal_req_t rq;
    rq = '{OP_DATE_TO_COUNT, ddn_pkg::YearW'(y), ddn_pkg::MonthW'(m), ddn_pkg::DayW'(d),
           ddn_pkg::CountW'($urandom)};
    send_request(rq);
  endtask

  task automatic send_count(int unsigned c);
    cal_req_t rq;
    rq = '{OP_COUNT_TO_DATE, ddn_pkg::YearW'($urandom), ddn_pkg::MonthW'($urandom),
           ddn_pkg::DayW'($urandom), ddn_pkg::CountW'(c)};
    send_request(rq);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_cal_q.size() != 0);
  endtask

  function automatic cal_req_t random_request(int unsigned last_day);
    cal_req_t    rq;
    int unsigned pick;
    rq   = '{conv_op_e'($urandom_range(1)), ddn_pkg::YearW'($urandom),
             ddn_pkg::MonthW'($urandom), ddn_pkg::DayW'($urandom),
             ddn_pkg::CountW'($urandom)};
    pick = $urandom_range(99);
    if (pick < 40) begin
      rq.op    = OP_DATE_TO_COUNT;
      rq.year  = ddn_pkg::YearW'(FIRST_YEAR + $urandom_range(SPAN - 1));
      rq.month = ddn_pkg::MonthW'($urandom_range(12, 1));
      rq.day   = ($urandom_range(99) < 85) ?
                 ddn_pkg::DayW'($urandom_range(days_in_month(rq.year, rq.month), 1)) :
                 ddn_pkg::DayW'($urandom_range(31, 1));
    end else if (pick < 80) begin
      rq.op        = OP_COUNT_TO_DATE;
      rq.day_count = ddn_pkg::CountW'($urandom_range(last_day));
    end else if (pick < 90) begin
      rq.op        = OP_COUNT_TO_DATE;
    end else begin
      rq.op        = OP_DATE_TO_COUNT;
    end
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_dates();
    send_date(1900, 1, 1);
    send_date(1900, 2, 29);     // 1900 is not leap, day simply added
    send_date(1904, 2, 29);
    send_date(2000, 2, 29);     // leap by the 400 rule
    send_date(2100, 3, 1);
    send_date(2155, 12, 31);
    send_date(1999, 4, 31);
    send_date(2023, 2, 31);
    send_date(2024, 0, 15);
    send_date(2024, 13, 1);
    send_date(2024, 15, 31);
    send_date(2024, 6, 0);
    send_date(1899, 12, 31);
    send_date(2156, 1, 1);
    send_date(4095, 15, 31);
    send_date(0, 0, 0);
  endtask

  task automatic test_directed_counts();
    send_count(0);
    send_count(59);
    send_count(60);
    send_count(36524);
    send_count(36525);
    send_count(span_days() - 1);
    send_count(span_days());     // first count past the span
    send_count(ddn_pkg::CountMax);
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned last_day;
    last_day = span_days() - 1;
    repeat (n) send_request(random_request(last_day));
  endtask

  task automatic test_long_hold();
    hold_go = 1'b1;
    test_random_mix(10);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = '0;
    in_if.year      = '0;
    in_if.month     = '0;
    in_if.day       = '0;
    in_if.day_count = '0;
    out_if.ready    = 1'b0;
    hold_go         = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    mismatches      = 0;
    n_date_req      = 0;
    n_count_req     = 0;
    n_flagged       = 0;
    n_results       = 0;
    src_idle_pct    = 23;
    snk_idle_pct    = 52;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_dates();
    test_directed_counts();
    test_random_mix(200);
    drain_results();

    src_idle_pct = 52;
    snk_idle_pct = 23;
    test_random_mix(200);
    test_long_hold();
    drain_results();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_mix(210);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d dates and %0d day counts; %0d results flagged invalid.",
             n_date_req, n_count_req, n_flagged);
    $display("Phases: sender/receiver idling 23/52, 52/23, none; one %0d-cycle hold.",
             LONG_HOLD);
    if (mismatches == 0 && expected_cal_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_cal_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
